>>> rtl/core/npl_pkg.sv
// ----------------------------------------------------------------------------
// npl_pkg
// Types, codes and constants shared by the nearest point lookup block.
// ----------------------------------------------------------------------------
package npl_pkg;

    localparam int NPL_CAPACITY = 1024;
    localparam int POS_W        = 32;
    localparam int NUM_W        = 11;

    // request kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0] point_number;
        logic             no_entries;
    } t_out_item;

    // one table slot
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [NUM_W-1:0]        num;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic start_load;
        logic start_query;
        logic ld_rd;
        logic ld_shift;
        logic ld_place;
        logic q_rd;
        logic q_step;
        logic q_setr;
        logic q_rdl;
        logic q_rdr;
        logic q_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic rd_gt;
        logic lo_eq_hi;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/npl_ctrl.sv
// ----------------------------------------------------------------------------
// npl_ctrl
// Sequencer for clear, insertion load and binary search query.
// ----------------------------------------------------------------------------
module npl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_kind,
    input  npl_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output npl_pkg::t_cmd   o_cmd
);
    import npl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LD_RD  = 9'b000000010,
        S_LD_CMP = 9'b000000100,
        S_Q_RD   = 9'b000001000,
        S_Q_CMP  = 9'b000010000,
        S_Q_FIN  = 9'b000100000,
        S_Q_RDL  = 9'b001000000,
        S_Q_RDR  = 9'b010000000,
        S_Q_SEL  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_CLEAR: o_cmd.clear = 1'b1;
                        KIND_LOAD: begin
                            if (!i_stat.full) begin
                                o_cmd.start_load = 1'b1;
                                n_state = S_LD_RD;
                            end
                        end
                        KIND_QUERY: begin
                            o_cmd.start_query = 1'b1;
                            n_state = i_stat.empty ? S_Q_SEL : S_Q_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.ld_place = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ld_rd = 1'b1;
                    n_state = S_LD_CMP;
                end
            end
            S_LD_CMP: begin
                if (i_stat.rd_gt) begin
                    o_cmd.ld_shift = 1'b1;
                    n_state = S_LD_RD;
                end else begin
                    o_cmd.ld_place = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_Q_RD: begin
                if (i_stat.lo_eq_hi) begin
                    n_state = S_Q_FIN;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state = S_Q_CMP;
                end
            end
            S_Q_CMP: begin
                o_cmd.q_step = 1'b1;
                n_state = S_Q_RD;
            end
            S_Q_FIN: begin
                o_cmd.q_setr = 1'b1;
                n_state = S_Q_RDL;
            end
            S_Q_RDL: begin
                o_cmd.q_rdl = 1'b1;
                n_state = S_Q_RDR;
            end
            S_Q_RDR: begin
                o_cmd.q_rdr = 1'b1;
                n_state = S_Q_SEL;
            end
            S_Q_SEL: begin
                if (i_stat.out_free) begin
                    o_cmd.q_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/npl_dp.sv
// ----------------------------------------------------------------------------
// npl_dp
// Sorted table memory, search pointers, distance compare and result register.
// ----------------------------------------------------------------------------
module npl_dp #(
    parameter int CAPACITY = npl_pkg::NPL_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  npl_pkg::t_in_item  i_in_data,
    input  npl_pkg::t_cmd      i_cmd,
    input  logic               i_out_ready,
    output npl_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output npl_pkg::t_out_item o_out_data
);
    import npl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_entry mem [CAPACITY];

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [CW-1:0]           r_mid;
    logic [CW-1:0]           r_r;
    logic                    r_force;
    logic                    r_empty;
    logic signed [POS_W-1:0] r_q;
    t_entry                  r_rdata;
    t_entry                  r_left;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid_calc;
    logic [CW-1:0]           rd_idx;
    logic                    rd_en;
    logic [CW-1:0]           idx_m1;
    logic [CW-1:0]           r_m1;
    logic [NUM_W-1:0]        new_num;
    logic signed [POS_W:0]   dist_l;
    logic signed [POS_W:0]   dist_r;
    logic                    pick_left;
    logic                    out_take;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_calc = mid_sum[CW:1];
    assign idx_m1   = r_idx - 1'b1;
    assign r_m1     = r_r - 1'b1;
    assign new_num  = NUM_W'({1'b0, r_count} + 1'b1);

    // read address select
    always_comb begin
        rd_en  = i_cmd.ld_rd || i_cmd.q_rd || i_cmd.q_rdl || i_cmd.q_rdr;
        rd_idx = '0;
        if (i_cmd.ld_rd) begin
            rd_idx = idx_m1;
        end else if (i_cmd.q_rd) begin
            rd_idx = mid_calc;
        end else if (i_cmd.q_rdl) begin
            rd_idx = (r_r == '0) ? '0 : r_m1;
        end else if (i_cmd.q_rdr) begin
            rd_idx = r_r;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_idx[AW-1:0]];
        end
        if (i_cmd.ld_shift) begin
            mem[r_idx[AW-1:0]] <= r_rdata;
        end else if (i_cmd.ld_place) begin
            mem[r_idx[AW-1:0]] <= '{pos: r_q, num: new_num};
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.ld_place) begin
            r_count <= r_count + 1'b1;
        end
    end

    // search and insertion pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load || i_cmd.start_query) begin
            r_q     <= i_in_data.position;
            r_idx   <= r_count;
            r_lo    <= '0;
            r_hi    <= r_count;
            r_empty <= (r_count == '0);
        end
        if (i_cmd.ld_shift) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.q_rd) begin
            r_mid <= mid_calc;
        end
        if (i_cmd.q_step) begin
            if (r_rdata.pos < r_q) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.q_setr) begin
            if (r_lo == r_count) begin
                r_r     <= r_count - 1'b1;
                r_force <= 1'b1;
            end else if (r_count == CW'(1)) begin
                r_r     <= '0;
                r_force <= 1'b1;
            end else begin
                r_r     <= (r_lo == '0) ? CW'(1) : r_lo;
                r_force <= 1'b0;
            end
        end
        if (i_cmd.q_rdr) begin
            r_left <= r_rdata;
        end
    end

    // neighbor distances at 33 bits, tie goes right
    assign dist_l    = {r_q[POS_W-1], r_q} - {r_left.pos[POS_W-1], r_left.pos};
    assign dist_r    = {r_rdata.pos[POS_W-1], r_rdata.pos} - {r_q[POS_W-1], r_q};
    assign pick_left = !r_force && (dist_l < dist_r);

    // result register
    assign out_take = r_out_valid && i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.q_out) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_out) begin
            r_out.no_entries   <= r_empty;
            r_out.point_number <= r_empty ? '0 :
                                  (pick_left ? r_left.num : r_rdata.num);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status to controller
    assign o_stat.full     = (r_count == CW'(CAPACITY));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.rd_gt    = (r_rdata.pos > r_q);
    assign o_stat.lo_eq_hi = (r_lo == r_hi);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

>>> rtl/core/nearest_point_lookup.sv
// ----------------------------------------------------------------------------
// nearest_point_lookup
// Sorted table of points on a line with nearest point query by binary search.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  request  | in        | i_in_valid / o_in_ready | i_in_data  (kind, position)
//  result   | out       | o_out_valid/ i_out_ready| o_out_data (point_number, no_entries)
//
//  clear, ignored requests and loads into a full table finish in the idle
//  state; a load moves each larger entry up one slot, top down, and places
//  the new point in the slot freed or in slot 0 (single read and write port).
//  a query makes p binary search probes over the table memory, a read and a
//  compare each, at most floor(log2(n)) + 1, then reads both neighbors.
//  a query on an empty table goes straight to the result register.
//  reset is synchronous, active low; it empties the table.
//  a finished result waits in the output register; a query whose result
//  finds it still full holds until it is taken.
module nearest_point_lookup #(
    parameter int CAPACITY = npl_pkg::NPL_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  npl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output npl_pkg::t_out_item o_out_data
);
    import npl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    npl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // table and search datapath
    npl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/npl_checker.sv
// ----------------------------------------------------------------------------
// npl_props
// Port level checks for the nearest point lookup block.
// ----------------------------------------------------------------------------
module npl_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input npl_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input npl_pkg::t_out_item o_out_data
);
    import npl_pkg::*;

    // a pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before taken");

    // reset leaves no result
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // empty table answer carries number zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_entries |-> o_out_data.point_number == '0)
        else $error("empty answer with nonzero number");

    // accepted query keeps the block busy for the search
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.kind == KIND_QUERY |=> !o_in_ready)
        else $error("request taken during query");

    // a new result appears only while the block is busy
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without query");

endmodule

bind nearest_point_lookup npl_props u_npl_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> dv/npl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npl_checker
// Watches both channels of the nearest point lookup block, keeps its own
// sorted table, predicts each query result and compares it field by field.
// ----------------------------------------------------------------------------
module npl_checker
    import npl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic signed [POS_W-1:0] tbl_pos [NPL_CAPACITY];
    logic [NUM_W-1:0]        tbl_num [NPL_CAPACITY];
    int                      tbl_count;
    t_out_item               expected_results [$];

    assign o_pending = expected_results.size();

    // stable insert after every entry at or below p
    task automatic table_load(input logic signed [POS_W-1:0] p);
        int ins;
        if (tbl_count >= NPL_CAPACITY) return;
        ins = tbl_count;
        while (ins > 0 && tbl_pos[ins-1] > p) ins--;
        for (int i = tbl_count; i > ins; i--) begin
            tbl_pos[i] = tbl_pos[i-1];
            tbl_num[i] = tbl_num[i-1];
        end
        tbl_pos[ins] = p;
        tbl_num[ins] = NUM_W'(tbl_count + 1);
        tbl_count++;
    endtask

    function automatic t_out_item nearest_point(input logic signed [POS_W-1:0] q);
        t_out_item res;
        int r;
        logic signed [POS_W:0] dl, dr;
        res = '0;
        if (tbl_count == 0) begin
            res.no_entries = 1'b1;
            return res;
        end
        if (q < tbl_pos[0]) res.point_number = tbl_num[0];
        else if (q > tbl_pos[tbl_count-1]) res.point_number = tbl_num[tbl_count-1];
        else if (tbl_count == 1) res.point_number = tbl_num[0];
        else begin
            r = 1;
            while (r < tbl_count - 1 && tbl_pos[r] < q) r++;
            dl = {q[POS_W-1], q} - {tbl_pos[r-1][POS_W-1], tbl_pos[r-1]};
            dr = {tbl_pos[r][POS_W-1], tbl_pos[r]} - {q[POS_W-1], q};
            res.point_number = (dl < dr) ? tbl_num[r-1] : tbl_num[r];
        end
        return res;
    endfunction

    // track requests and compare results
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            tbl_count = 0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.kind)
                    KIND_CLEAR: tbl_count = 0;
                    KIND_LOAD:  table_load(i_in_data.position);
                    KIND_QUERY: expected_results.push_back(nearest_point(i_in_data.position));
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: %0d/%0b",
                            i_out_data.point_number, i_out_data.no_entries);
                end else begin
                    exp_item = expected_results.pop_front();
                    if (exp_item.point_number !== i_out_data.point_number ||
                        exp_item.no_entries !== i_out_data.no_entries) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %0d/%0b actual %0d/%0b",
                                exp_item.point_number, exp_item.no_entries,
                                i_out_data.point_number, i_out_data.no_entries);
                    end
                end
            end
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, load and query requests into the nearest point lookup block
// with random idling and back pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import npl_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    bit        quiet_phase = 1'b0;
    bit        hold_start = 1'b0;
    bit        hold_off = 1'b0;
    int        idle_cycles = 0;

    always #10 clk = ~clk;

    nearest_point_lookup dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    npl_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result side: random stall bursts, long hold-off on demand
    always @(posedge clk) begin
        int burst;
        if (!rst_n || hold_off) out_ready <= 1'b0;
        else if (quiet_phase) out_ready <= 1'b1;
        else if (burst > 0) begin
            burst--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 19);
            out_ready <= 1'b0;
        end else out_ready <= 1'b1;
    end

    // long receiver hold-off, counted here while requests keep coming
    initial begin
        wait (hold_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(input logic [1:0] k, input logic signed [POS_W-1:0] p);
        in_valid <= 1'b1;
        in_data  <= '{kind: k, position: p};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_position(input int span);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2 * span)) - span;
            default: return $signed($urandom_range(0, span));
        endcase
    endfunction

    // directed and random requests
    task automatic send_item(input logic [1:0] k, input logic signed [POS_W-1:0] p);
        send(k, p);
        sender_gap();
    endtask

    initial begin
        int span;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, ties, empty table, unused kind
        send_item(KIND_QUERY, 0);
        send_item(KIND_RSVD, 5);
        send_item(KIND_LOAD, 32'sh7fffffff);
        send_item(KIND_QUERY, 32'sh80000000);
        send_item(KIND_QUERY, 32'sh7fffffff);
        send_item(KIND_LOAD, 32'sh80000000);
        send_item(KIND_QUERY, 0);
        send_item(KIND_QUERY, -1);
        send_item(KIND_LOAD, 10);
        send_item(KIND_LOAD, 10);
        send_item(KIND_LOAD, 20);
        send_item(KIND_QUERY, 15);
        send_item(KIND_QUERY, 14);
        send_item(KIND_QUERY, 16);
        send_item(KIND_QUERY, 10);
        send_item(KIND_QUERY, 32'sh80000000);
        send_item(KIND_QUERY, 32'sh7fffffff);
        send_item(KIND_CLEAR, 0);
        send_item(KIND_QUERY, 3);
        send_item(KIND_LOAD, -7);
        send_item(KIND_QUERY, 100);

        // long result stall while requests keep coming
        hold_start = 1'b1;
        for (int i = 0; i < 12; i++) send(KIND_QUERY, $urandom());
        in_valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);

        // fill the table to capacity, then loads into a full table
        send_item(KIND_CLEAR, 0);
        for (int i = 0; i < NPL_CAPACITY + 3; i++) begin
            send(KIND_LOAD, rand_position(1000));
            if (i % 97 == 0) send(KIND_QUERY, rand_position(1000));
        end

        // random requests on the full table, then on small tables after a clear, some with close positions
        for (int i = 0; i < 40; i++) begin
            if (i >= 28) quiet_phase = 1'b1;
            span = ($urandom_range(0, 1)) ? 16 : 100000;
            case ($urandom_range(0, 19))
                0:       send_item(KIND_CLEAR, $urandom());
                1:       send_item(KIND_RSVD, $urandom());
                2, 3, 4, 5, 6, 7, 8: send_item(KIND_LOAD, rand_position(span));
                default: send_item(KIND_QUERY, rand_position(span));
            endcase
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (3000) @(posedge clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
